// ===== rtl/core/hbkrd_pkg.sv =====
// Shared package of the HID boot keyboard report decoder.
// Holds slot constants, event codes, control/status structs and the key tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbkrd_pkg;

  // Report geometry.
  localparam int KEY_SLOTS = 6;
  localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  // Modifier masks, left and right side together.
  localparam logic [7:0] SHIFT_MASK     = 8'h22;
  localparam logic [7:0] CTRL_MASK      = 8'h11;
  localparam logic [6:0] CTRL_CHAR_MASK = 7'h1f;

  // Event kinds.
  localparam logic EV_NAV  = 1'b0;
  localparam logic EV_CHAR = 1'b1;

  // Navigation codes.
  localparam logic [4:0] NAV_NONE  = 5'd0;
  localparam logic [4:0] NAV_ESC   = 5'd1;
  localparam logic [4:0] NAV_ENTER = 5'd2;
  localparam logic [4:0] NAV_TAB   = 5'd3;
  localparam logic [4:0] NAV_BKSP  = 5'd4;
  localparam logic [4:0] NAV_UP    = 5'd5;
  localparam logic [4:0] NAV_DOWN  = 5'd6;
  localparam logic [4:0] NAV_LEFT  = 5'd7;
  localparam logic [4:0] NAV_RIGHT = 5'd8;
  localparam logic [4:0] NAV_HOME  = 5'd9;
  localparam logic [4:0] NAV_END   = 5'd10;
  localparam logic [4:0] NAV_PGUP  = 5'd11;
  localparam logic [4:0] NAV_PGDN  = 5'd12;
  localparam logic [4:0] NAV_F1    = 5'd13;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic eval;   // build the event mask and store the report as previous
    logic emit;   // send the lowest pending event to the output register
  } hbkrd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_event;     // the report under evaluation yields at least one event
    logic last_pending;  // exactly one event remains in the mask
    logic out_free;      // the output register can take a new event
  } hbkrd_sts_t;

  // Navigation code of a usage code, NAV_NONE when it is no navigation key.
  function automatic logic [4:0] nav_of(input logic [7:0] code);
    logic [4:0] nav;
    nav = NAV_NONE;
    if (code >= 8'h3a && code <= 8'h45) begin
      nav = 5'(code - 8'h3a) + NAV_F1;
    end else begin
      case (code)
        8'h29:   nav = NAV_ESC;
        8'h28:   nav = NAV_ENTER;
        8'h2b:   nav = NAV_TAB;
        8'h2a:   nav = NAV_BKSP;
        8'h4c:   nav = NAV_BKSP;
        8'h52:   nav = NAV_UP;
        8'h51:   nav = NAV_DOWN;
        8'h50:   nav = NAV_LEFT;
        8'h4f:   nav = NAV_RIGHT;
        8'h4a:   nav = NAV_HOME;
        8'h4d:   nav = NAV_END;
        8'h4b:   nav = NAV_PGUP;
        8'h4e:   nav = NAV_PGDN;
        default: nav = NAV_NONE;
      endcase
    end
    return nav;
  endfunction

  // US layout character of a usage code, zero when the code has no entry.
  function automatic logic [6:0] char_of(input logic [7:0] code, input logic shifted);
    logic [6:0] un;
    logic [6:0] sh;
    un = 7'h00;
    sh = 7'h00;
    if (code >= 8'h04 && code <= 8'h1d) begin
      un = 7'(code - 8'h04) + 7'h61;
      sh = un - 7'h20;
    end else begin
      case (code)
        8'h1e:   begin un = 7'h31; sh = 7'h21; end
        8'h1f:   begin un = 7'h32; sh = 7'h40; end
        8'h20:   begin un = 7'h33; sh = 7'h23; end
        8'h21:   begin un = 7'h34; sh = 7'h24; end
        8'h22:   begin un = 7'h35; sh = 7'h25; end
        8'h23:   begin un = 7'h36; sh = 7'h5e; end
        8'h24:   begin un = 7'h37; sh = 7'h26; end
        8'h25:   begin un = 7'h38; sh = 7'h2a; end
        8'h26:   begin un = 7'h39; sh = 7'h28; end
        8'h27:   begin un = 7'h30; sh = 7'h29; end
        8'h2c:   begin un = 7'h20; sh = 7'h20; end
        8'h2d:   begin un = 7'h2d; sh = 7'h5f; end
        8'h2e:   begin un = 7'h3d; sh = 7'h2b; end
        8'h2f:   begin un = 7'h5b; sh = 7'h7b; end
        8'h30:   begin un = 7'h5d; sh = 7'h7d; end
        8'h31:   begin un = 7'h5c; sh = 7'h7c; end
        8'h33:   begin un = 7'h3b; sh = 7'h3a; end
        8'h34:   begin un = 7'h27; sh = 7'h22; end
        8'h35:   begin un = 7'h60; sh = 7'h7e; end
        8'h36:   begin un = 7'h2c; sh = 7'h3c; end
        8'h37:   begin un = 7'h2e; sh = 7'h3e; end
        8'h38:   begin un = 7'h2f; sh = 7'h3f; end
        default: begin un = 7'h00; sh = 7'h00; end
      endcase
    end
    return shifted ? sh : un;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hbkrd_ifs.sv =====
// Channel interfaces of the HID boot keyboard report decoder.
// hbkrd_in_if carries one keyboard report, hbkrd_out_if one decoded event.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hbkrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] key_0;
  logic [7:0] key_1;
  logic [7:0] key_2;
  logic [7:0] key_3;
  logic [7:0] key_4;
  logic [7:0] key_5;

  modport source (output valid, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
                  input ready);
  modport sink (input valid, modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5,
                output ready);
endinterface

interface hbkrd_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [4:0] nav_code;
  logic [6:0] char_code;
  logic [7:0] modifier_out;
  logic       last;

  modport source (output valid, event_kind, nav_code, char_code, modifier_out, last,
                  input ready);
  modport sink (input valid, event_kind, nav_code, char_code, modifier_out, last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hid_boot_keyboard_report_decoder.sv =====
// Top level of the HID boot keyboard report decoder.
// Joins hbkrd_ctrl and hbkrd_datapath to the channel interfaces; uses hbkrd_pkg, hbkrd_ifs.
//
//   Channel | Interface    | Direction | Payload
//   in_ch   | hbkrd_in_if  | sink      | modifier_bits, key_0 .. key_5 (one report)
//   out_ch  | hbkrd_out_if | source    | event_kind, nav_code, char_code, modifier_out, last
//
// A report is captured, then compared against the previous report to build the event mask,
// and then its events (0 to 6) are sent one at a time through the emit state.
// Events go out in slot order through a single output register; a stalled output holds
// the controller in its emit state. Reset (rst_n low, synchronous) clears the previous
// keys, the event mask and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module hid_boot_keyboard_report_decoder (
  input  logic        clk,
  input  logic        rst_n,
  hbkrd_in_if.sink    in_ch,
  hbkrd_out_if.source out_ch
);
  import hbkrd_pkg::*;

  hbkrd_cmd_t cmd;
  hbkrd_sts_t sts;

  // Sequencer.
  hbkrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Report storage, decode and output register.
  hbkrd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .modifier_bits (in_ch.modifier_bits),
    .key_0         (in_ch.key_0),
    .key_1         (in_ch.key_1),
    .key_2         (in_ch.key_2),
    .key_3         (in_ch.key_3),
    .key_4         (in_ch.key_4),
    .key_5         (in_ch.key_5),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .event_kind    (out_ch.event_kind),
    .nav_code      (out_ch.nav_code),
    .char_code     (out_ch.char_code),
    .modifier_out  (out_ch.modifier_out),
    .last          (out_ch.last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hbkrd_ctrl.sv =====
// Controller state machine of the HID boot keyboard report decoder.
// Sequences capture, evaluation and event emission. Depends on hbkrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbkrd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hbkrd_pkg::hbkrd_sts_t sts,
  output hbkrd_pkg::hbkrd_cmd_t cmd
);
  import hbkrd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Commands follow directly from the state and the handshakes.
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.load = in_valid && (state_r == ST_IDLE);
    cmd.eval = (state_r == ST_EVAL);
    cmd.emit = (state_r == ST_EMIT) && sts.out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = sts.any_event ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (cmd.emit && sts.last_pending) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hbkrd_datapath.sv =====
// Datapath of the HID boot keyboard report decoder.
// Holds the captured report, the previous keys, the event mask and the output register.
// Depends on hbkrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbkrd_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            modifier_bits,
  input  logic [7:0]            key_0,
  input  logic [7:0]            key_1,
  input  logic [7:0]            key_2,
  input  logic [7:0]            key_3,
  input  logic [7:0]            key_4,
  input  logic [7:0]            key_5,
  input  hbkrd_pkg::hbkrd_cmd_t cmd,
  output hbkrd_pkg::hbkrd_sts_t sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  event_kind,
  output logic [4:0]            nav_code,
  output logic [6:0]            char_code,
  output logic [7:0]            modifier_out,
  output logic                  last
);
  import hbkrd_pkg::*;

  logic [7:0]           mod_r;
  logic [7:0]           keys_r [KEY_SLOTS];
  logic [7:0]           prev_r [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] mask_r;
  logic [KEY_SLOTS-1:0] mask_eval;
  logic [KEY_SLOTS-1:0] mask_rest;
  logic [SLOT_W-1:0]    sel;
  logic [7:0]           sel_code;
  logic [4:0]           sel_nav;
  logic [6:0]           sel_char;
  logic                 shifted;
  logic                 ctrl;

  logic                 out_valid_r;
  logic                 event_kind_r;
  logic [4:0]           nav_code_r;
  logic [6:0]           char_code_r;
  logic [7:0]           modifier_out_r;
  logic                 last_r;

  // Capture of the incoming request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r     <= modifier_bits;
      keys_r[0] <= key_0;
      keys_r[1] <= key_1;
      keys_r[2] <= key_2;
      keys_r[3] <= key_3;
      keys_r[4] <= key_4;
      keys_r[5] <= key_5;
    end
  end

  // A slot yields an event when its code is new and decodes to something.
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      logic seen;
      seen = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_r[j] == keys_r[i]) seen = 1'b1;
      end
      mask_eval[i] = !seen &&
                     ((nav_of(keys_r[i]) != NAV_NONE) || (char_of(keys_r[i], 1'b0) != 7'h00));
    end
  end

  // Lowest pending slot and what remains after it.
  always_comb begin
    sel = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = SLOT_W'(i);
    end
  end

  assign mask_rest = mask_r & (mask_r - KEY_SLOTS'(1));

  // Decode of the selected slot.
  assign shifted  = (mod_r & SHIFT_MASK) != 8'h00;
  assign ctrl     = (mod_r & CTRL_MASK) != 8'h00;
  assign sel_code = keys_r[sel];
  assign sel_nav  = nav_of(sel_code);
  assign sel_char = char_of(sel_code, shifted) & (ctrl ? CTRL_CHAR_MASK : 7'h7f);

  // Mask and previous report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) prev_r[i] <= 8'h00;
    end else if (cmd.eval) begin
      mask_r <= mask_eval;
      for (int i = 0; i < KEY_SLOTS; i++) prev_r[i] <= keys_r[i];
    end else if (cmd.emit) begin
      mask_r <= mask_rest;
    end
  end

  // Output register: holds one event until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_kind_r   <= (sel_nav != NAV_NONE) ? EV_NAV : EV_CHAR;
      nav_code_r     <= sel_nav;
      char_code_r    <= (sel_nav != NAV_NONE) ? 7'h00 : sel_char;
      modifier_out_r <= mod_r;
      last_r         <= (mask_rest == '0);
    end
  end

  // Status to the controller.
  always_comb begin
    sts              = '0;
    sts.any_event    = (mask_eval != '0);
    sts.last_pending = (mask_rest == '0);
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign event_kind   = event_kind_r;
  assign nav_code     = nav_code_r;
  assign char_code    = char_code_r;
  assign modifier_out = modifier_out_r;
  assign last         = last_r;

  // An event is only sent while one is pending.
  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (mask_r != '0))
    else $error("emit with an empty event mask");

  // A new request is only captured once every event of the previous one has left the mask.
  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (mask_r == '0))
    else $error("request captured while events are pending");

  // Sending the final event empties the mask and marks it last.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_pending) |=> (mask_r == '0) && out_valid_r && last_r)
    else $error("final event not flagged or mask not empty");

  // An emitted event shows up in the output register.
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted event missing from output register");

endmodule

`default_nettype wire

// ===== tb/tb_hid_boot_keyboard_report_decoder.sv =====
// Self-checking testbench of the HID boot keyboard report decoder.
// Sends keyboard reports and checks every decoded key event against an in-bench model.
// Depends on hbkrd_pkg, hbkrd_ifs and hid_boot_keyboard_report_decoder.
`timescale 1ns / 1ps

module tb_hid_boot_keyboard_report_decoder;
  import hbkrd_pkg::*;

  // One boot keyboard report; slot 0 sits in the low byte of keys.
  typedef struct packed {
    logic [7:0]                mods;
    logic [KEY_SLOTS-1:0][7:0] keys;
  } kbd_report_t;

  // One decoded key event as the output channel carries it.
  typedef struct packed {
    logic       kind;
    logic [4:0] nav;
    logic [6:0] chr;
    logic [7:0] mods;
    logic       last;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hbkrd_in_if  in_ch ();
  hbkrd_out_if out_ch ();

  hid_boot_keyboard_report_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Keys of the last accepted report, as the decoder should remember them.
  logic [KEY_SLOTS-1:0][7:0] held_keys;
  key_event_t                pending_events[$];
  kbd_report_t               last_report;

  int  mismatch_count = 0;
  int  reports_sent   = 0;
  int  events_checked = 0;
  int  rx_hold_cycles = 0;
  bit  idling_on      = 1'b1;

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("[hid_boot_keyboard_report_decoder] ERROR");
    $finish;
  end

  // Idle length: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Navigation code of a usage code, NAV_NONE for all other keys.
  function automatic logic [4:0] nav_key(input logic [7:0] code);
    if (code >= 8'h3a && code <= 8'h45) return NAV_F1 + 5'(code - 8'h3a);
    case (code)
      8'h28: return NAV_ENTER;
      8'h29: return NAV_ESC;
      8'h2a: return NAV_BKSP;
      8'h2b: return NAV_TAB;
      8'h4a: return NAV_HOME;
      8'h4b: return NAV_PGUP;
      8'h4c: return NAV_BKSP;
      8'h4d: return NAV_END;
      8'h4e: return NAV_PGDN;
      8'h4f: return NAV_RIGHT;
      8'h50: return NAV_LEFT;
      8'h51: return NAV_DOWN;
      8'h52: return NAV_UP;
      default: return NAV_NONE;
    endcase
  endfunction

  // US layout character of a usage code, zero when the key has none.
  function automatic logic [6:0] us_char(input logic [7:0] code, input bit shifted);
    string digits;
    string digits_up;
    string punct;
    string punct_up;
    string marks;
    string marks_up;
    byte   ch;
    digits    = "1234567890";
    digits_up = "!@#$%^&*()";
    punct     = " -=[]\\";
    punct_up  = " _+{}|";
    marks     = ";'`,./";
    marks_up  = ":\"~<>?";
    ch = 8'h00;
    if (code >= 8'h04 && code <= 8'h1d)
      ch = (shifted ? 8'h41 : 8'h61) + (code - 8'h04);
    else if (code >= 8'h1e && code <= 8'h27)
      ch = shifted ? digits_up[code - 8'h1e] : digits[code - 8'h1e];
    else if (code >= 8'h2c && code <= 8'h31)
      ch = shifted ? punct_up[code - 8'h2c] : punct[code - 8'h2c];
    else if (code >= 8'h33 && code <= 8'h38)
      ch = shifted ? marks_up[code - 8'h33] : marks[code - 8'h33];
    return ch[6:0];
  endfunction

  // Work out the events of one accepted report and remember its keys.
  function automatic void decode_report(input kbd_report_t rpt);
    bit         shifted;
    bit         ctrl;
    bit         seen;
    bit         have_prev;
    logic [7:0] code;
    logic [4:0] nav;
    logic [6:0] chr;
    key_event_t evt;
    key_event_t prev_evt;
    shifted   = (rpt.mods & SHIFT_MASK) != 8'h00;
    ctrl      = (rpt.mods & CTRL_MASK) != 8'h00;
    have_prev = 1'b0;
    prev_evt  = '0;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      code = rpt.keys[s];
      seen = 1'b0;
      for (int p = 0; p < KEY_SLOTS; p++)
        if (held_keys[p] == code) seen = 1'b1;
      if (code > 8'h01 && !seen) begin
        nav = nav_key(code);
        chr = us_char(code, shifted);
        evt = '0;
        evt.mods = rpt.mods;
        if (nav != NAV_NONE) begin
          evt.kind = EV_NAV;
          evt.nav  = nav;
        end else begin
          evt.kind = EV_CHAR;
          evt.chr  = ctrl ? (chr & CTRL_CHAR_MASK) : chr;
        end
        // A key with neither meaning gives no event.
        if (nav != NAV_NONE || chr != 7'h00) begin
          if (have_prev) pending_events.push_back(prev_evt);
          prev_evt  = evt;
          have_prev = 1'b1;
        end
      end
    end
    // The final event of the report carries the last flag.
    if (have_prev) begin
      prev_evt.last = 1'b1;
      pending_events.push_back(prev_evt);
    end
    held_keys = rpt.keys;
  endfunction

  // Offer one report and wait until the decoder takes the request.
  task automatic send_report(input kbd_report_t rpt);
    int gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.modifier_bits = rpt.mods;
    in_ch.key_0 = rpt.keys[0];
    in_ch.key_1 = rpt.keys[1];
    in_ch.key_2 = rpt.keys[2];
    in_ch.key_3 = rpt.keys[3];
    in_ch.key_4 = rpt.keys[4];
    in_ch.key_5 = rpt.keys[5];
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    decode_report(rpt);
    last_report = rpt;
    reports_sent++;
  endtask

  task automatic send_keys(input logic [7:0] mods, input logic [7:0] k0, input logic [7:0] k1,
                           input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4,
                           input logic [7:0] k5);
    kbd_report_t rpt;
    rpt.mods = mods;
    rpt.keys = {k5, k4, k3, k2, k1, k0};
    send_report(rpt);
  endtask

  // Letters, digits and punctuation under every Shift and Ctrl combination.
  task automatic test_character_keys();
    send_keys(8'h00, 8'h04, 8'h05, 8'h1d, 8'h1e, 8'h27, 8'h38);
    send_keys(8'h22, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31);
    send_keys(8'h20, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h04);
    // Ctrl on space and on '@' masks the character down to zero.
    send_keys(8'h01, 8'h2c, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h13, 8'h1f, 8'h1d, 8'h23, 8'h00, 8'h00, 8'h00);
    send_keys(8'hff, 8'h38, 8'h04, 8'h27, 8'h00, 8'h00, 8'h00);
    send_keys(8'hcc, 8'h05, 8'h1e, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Every navigation key, Delete included; modifiers must not change them.
  task automatic test_navigation_keys();
    send_keys(8'h00, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h3a, 8'h3b);
    send_keys(8'h11, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41);
    send_keys(8'h22, 8'h42, 8'h43, 8'h44, 8'h45, 8'h4a, 8'h4b);
    send_keys(8'hff, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51);
    send_keys(8'h80, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Unused codes, rollover, repeats within a report, held and released keys.
  task automatic test_special_cases();
    send_keys(8'h00, 8'h02, 8'h03, 8'h32, 8'h39, 8'h53, 8'hff);
    send_keys(8'h00, 8'h46, 8'h47, 8'h48, 8'h49, 8'h64, 8'he0);
    send_keys(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
    send_keys(8'h00, 8'h04, 8'h04, 8'h28, 8'h28, 8'h04, 8'h00);
    send_keys(8'h00, 8'h04, 8'h04, 8'h28, 8'h28, 8'h04, 8'h00);
    send_keys(8'h00, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h02, 8'h00, 8'h06, 8'h01, 8'h00, 8'h4c, 8'h04);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Receiver stalls for a long time while full reports keep coming.
  task automatic test_output_backpressure();
    idling_on      = 1'b0;
    rx_hold_cycles = 300;
    for (int n = 0; n < 10; n++) begin
      if (n % 2 == 0)
        send_keys(8'($urandom), 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
      else
        send_keys(8'($urandom), 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f);
    end
    idling_on = 1'b1;
  endtask

  // Next report of a typing session: some keys held, some released, some new.
  function automatic kbd_report_t typing_report(input kbd_report_t prior);
    kbd_report_t rpt;
    int          n;
    int          adds;
    logic [7:0]  code;
    rpt = '0;
    n   = 0;
    case ($urandom_range(0, 3))
      0: rpt.mods = 8'h00;
      1: rpt.mods = 8'h01 << $urandom_range(0, 7);
      default: rpt.mods = 8'($urandom);
    endcase
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (prior.keys[s] > 8'h01 && $urandom_range(0, 1) == 1) begin
        rpt.keys[n] = prior.keys[s];
        n++;
      end
    end
    adds = $urandom_range(0, 3);
    for (int a = 0; a < adds; a++) begin
      if (n < KEY_SLOTS) begin
        if ($urandom_range(0, 9) == 0) code = 8'($urandom_range(8'h53, 8'hff));
        else code = 8'($urandom_range(8'h04, 8'h52));
        rpt.keys[n] = code;
        n++;
      end
    end
    return rpt;
  endfunction

  // Mostly typing sessions; the rest raw bytes, rollover and empty reports.
  task automatic test_random_reports(input int count);
    kbd_report_t rpt;
    int          pick;
    for (int n = 0; n < count; n++) begin
      idling_on = !(n >= 80 && n < 120);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        rpt = typing_report(last_report);
      end else if (pick < 85) begin
        rpt.mods = 8'($urandom);
        for (int s = 0; s < KEY_SLOTS; s++) rpt.keys[s] = 8'($urandom);
      end else if (pick < 93) begin
        rpt.mods = 8'($urandom);
        for (int s = 0; s < KEY_SLOTS; s++) rpt.keys[s] = 8'h01;
      end else begin
        rpt = '0;
      end
      send_report(rpt);
    end
    idling_on = 1'b1;
  endtask

  // Receiver side: random ready, always ready while idling is off, plus a counted hold-off when requested.
  initial begin
    int rx_gap;
    rx_gap = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        rx_hold_cycles--;
      end else if (!idling_on) begin
        out_ch.ready = 1'b1;
      end else if (rx_gap > 0) begin
        out_ch.ready = 1'b0;
        rx_gap--;
      end else begin
        out_ch.ready = 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  // Check each delivered event against the oldest expected one.
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      events_checked++;
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: event with none expected: kind=%0d nav=%0d char=%h mods=%h last=%0d",
                   $realtime, out_ch.event_kind, out_ch.nav_code, out_ch.char_code,
                   out_ch.modifier_out, out_ch.last);
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_kind !== want.kind || out_ch.nav_code !== want.nav ||
            out_ch.char_code !== want.chr || out_ch.modifier_out !== want.mods ||
            out_ch.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: event mismatch: expected kind=%0d nav=%0d char=%h mods=%h last=%0d,",
                     $realtime, want.kind, want.nav, want.chr, want.mods, want.last,
                     " got kind=%0d nav=%0d char=%h mods=%h last=%0d",
                     out_ch.event_kind, out_ch.nav_code, out_ch.char_code,
                     out_ch.modifier_out, out_ch.last);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.modifier_bits = 8'h00;
    in_ch.key_0         = 8'h00;
    in_ch.key_1         = 8'h00;
    in_ch.key_2         = 8'h00;
    in_ch.key_3         = 8'h00;
    in_ch.key_4         = 8'h00;
    in_ch.key_5         = 8'h00;
    held_keys           = '0;
    last_report         = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_character_keys();
    test_navigation_keys();
    test_special_cases();
    test_output_backpressure();
    test_random_reports(200);

    @(negedge clk);
    in_ch.valid = 1'b0;
    // Wait for all expected events, then watch for stray ones.
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Decoded %0d keyboard reports into %0d checked key events, %0d mismatches.",
             reports_sent, events_checked, mismatch_count);
    $display("Covered character, navigation and unused keys, rollover, held keys and stalls.");
    if (mismatch_count == 0)
      $display("[hid_boot_keyboard_report_decoder] OK");
    else
      $display("[hid_boot_keyboard_report_decoder] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hbkrd_pkg.sv
rtl/core/hbkrd_ifs.sv
rtl/core/hbkrd_ctrl.sv
rtl/core/hbkrd_datapath.sv
rtl/core/hid_boot_keyboard_report_decoder.sv
tb/tb_hid_boot_keyboard_report_decoder.sv
